@@ hdl/efu_pkg.sv @@
// package for the encoder feedback unwrap and filter unit
// holds the request and result types, register codes, encoder constants and filter step
// no dependencies
package efu_pkg;

  // encoder geometry
  localparam int unsigned ENCODER_COUNTS = 8192;
  localparam int unsigned ANGLE_W        = $clog2(ENCODER_COUNTS);
  localparam int unsigned DEG_W          = 17;
  localparam int unsigned DEG_SCALE      = 360 * 256;

  // configuration registers
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_ALPHA   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_ALPHA = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  ALPHA_RESET       = 16'd6554;

  // one feedback frame
  typedef struct packed {
    logic [7:0] angle_high_byte;
    logic [7:0] angle_low_byte;
    logic [7:0] speed_high_byte;
    logic [7:0] speed_low_byte;
    logic [7:0] current_high_byte;
    logic [7:0] current_low_byte;
    logic [7:0] temperature_byte;
  } efu_in_t;

  // one decoded and filtered result
  typedef struct packed {
    logic        [ANGLE_W-1:0] angle_counts;
    logic        [DEG_W-1:0]   angle_degrees_q8;
    logic signed [15:0]        speed_value;
    logic signed [15:0]        current_value;
    logic        [7:0]         temperature;
    logic signed [31:0]        total_angle_counts;
    logic signed [31:0]        speed_filtered_q16;
    logic signed [31:0]        current_filtered_q16;
  } efu_out_t;

  // first-order low-pass step y + floor(alpha * (x - y) / 2^16), x in Q16
  function automatic logic signed [31:0] lowpass_step(
    input logic signed [31:0] y,
    input logic signed [15:0] x_raw,
    input logic        [15:0] alpha
  );
    logic signed [31:0] x_q16;
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [33:0] sum;
    x_q16 = {x_raw, 16'h0000};
    diff  = {x_q16[31], x_q16} - {y[31], y};
    prod  = 50'($signed({1'b0, alpha})) * 50'(diff);
    sum   = {{2{y[31]}}, y} + prod[49:16];
    return sum[31:0];
  endfunction

endpackage

@@ hdl/efu_stream_if.sv @@
// valid/ready stream channel carrying one request per handshake
// payload type is set per instance, no package dependency
interface efu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/encoder_feedback_unwrap_filter_unit.sv @@
// encoder feedback unwrap and filter unit: a request passes the input register, then the
// result register; throughput one request per cycle while the result side is not stalled,
// with the turn count and both low-pass filters updated once per request
// reset clears angle, turn count, filter state and both valid flags; alphas reset to 6554
// depends on efu_pkg and efu_stream_if
module encoder_feedback_unwrap_filter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  efu_stream_if.sink                       in_i,
  efu_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [efu_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [efu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = efu_pkg::ANGLE_W;
  localparam logic [15:0] ANGLE_MAX = 16'(efu_pkg::ENCODER_COUNTS - 1);
  localparam logic signed [AW:0] HALF_TURN = (AW+1)'(efu_pkg::ENCODER_COUNTS / 2);
  localparam logic signed [32:0] FULL_TURN = 33'(efu_pkg::ENCODER_COUNTS);
  localparam logic [16:0] DEG_SCALE = 17'(efu_pkg::DEG_SCALE);
  localparam logic signed [31:0] TOTAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TOTAL_MIN = 32'sh8000_0000;

  logic              [15:0] speed_alpha_q, current_alpha_q;
  efu_pkg::efu_in_t         in_q;
  logic                     in_valid_q;
  efu_pkg::efu_out_t        out_q, out_d;
  logic                     out_valid_q;
  logic              [AW-1:0] prev_angle_q;
  logic signed       [31:0] turn_acc_q, turn_acc_d;
  logic signed       [31:0] speed_y_q, current_y_q;
  logic                     advance;

  logic [15:0]        angle_word;
  logic [AW-1:0]      angle;
  logic [AW+16:0]     deg_full;
  logic signed [AW:0] delta_raw;
  logic signed [32:0] delta;
  logic signed [32:0] total;

  // handshake: result register frees when empty or taken
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_alpha_q   <= efu_pkg::ALPHA_RESET;
      current_alpha_q <= efu_pkg::ALPHA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        efu_pkg::CFG_SPEED_ALPHA:   speed_alpha_q   <= cfg_data_i;
        efu_pkg::CFG_CURRENT_ALPHA: current_alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  // decode, clamp and convert angle
  always_comb begin
    angle_word = {in_q.angle_high_byte, in_q.angle_low_byte};
    angle      = (angle_word > ANGLE_MAX) ? ANGLE_MAX[AW-1:0] : angle_word[AW-1:0];
    deg_full   = {17'd0, angle} * {{AW{1'b0}}, DEG_SCALE};
  end

  // half-turn unwrap and saturating turn count
  always_comb begin
    delta_raw = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_q});
    delta     = {{(32-AW){delta_raw[AW]}}, delta_raw};
    if (delta_raw < -HALF_TURN) begin
      delta = delta + FULL_TURN;
    end else if (delta_raw > HALF_TURN) begin
      delta = delta - FULL_TURN;
    end
    total = {turn_acc_q[31], turn_acc_q} + delta;
    if (total[32] != total[31]) begin
      turn_acc_d = total[32] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      turn_acc_d = total[31:0];
    end
  end

  // result assembly
  always_comb begin
    out_d.angle_counts         = angle;
    out_d.angle_degrees_q8     = deg_full[AW +: efu_pkg::DEG_W];
    out_d.speed_value          = $signed({in_q.speed_high_byte, in_q.speed_low_byte});
    out_d.current_value        = $signed({in_q.current_high_byte, in_q.current_low_byte});
    out_d.temperature          = in_q.temperature_byte;
    out_d.total_angle_counts   = turn_acc_d;
    out_d.speed_filtered_q16   = efu_pkg::lowpass_step(speed_y_q, out_d.speed_value,
                                                       speed_alpha_q);
    out_d.current_filtered_q16 = efu_pkg::lowpass_step(current_y_q, out_d.current_value,
                                                       current_alpha_q);
  end

  // unwrap and filter state, updated once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      turn_acc_q   <= '0;
      speed_y_q    <= '0;
      current_y_q  <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        prev_angle_q <= angle;
        turn_acc_q   <= turn_acc_d;
        speed_y_q    <= out_d.speed_filtered_q16;
        current_y_q  <= out_d.current_filtered_q16;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a request in the input register moves on whenever the result side frees
  a_request_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("request lost between input and result register");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // the stored previous angle is the one last delivered
  a_prev_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> prev_angle_q == out_q.angle_counts)
    else $error("previous angle out of step with result");

  // the turn count state follows the delivered total
  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> turn_acc_q == out_q.total_angle_counts)
    else $error("turn count out of step with result");
`endif

endmodule

@@ tb/sv/tb_encoder_feedback_unwrap_filter_unit.sv @@
// testbench for the encoder feedback unwrap and filter unit: drives feedback frames,
// predicts each decoded result and checks it field by field against the block's output
// depends on efu_pkg, efu_stream_if and encoder_feedback_unwrap_filter_unit
module tb_encoder_feedback_unwrap_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TURN           = int'(efu_pkg::ENCODER_COUNTS);
  localparam int HALF_TURN      = TURN / 2;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF       = 4;
  localparam int RUN_LENGTH     = 52;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [efu_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [efu_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  efu_stream_if #(.payload_t(efu_pkg::efu_in_t))  frame_if ();
  efu_stream_if #(.payload_t(efu_pkg::efu_out_t)) result_if ();

  encoder_feedback_unwrap_filter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (frame_if),
    .out_o       (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // mirror of the block state and its registers
  logic [efu_pkg::ANGLE_W-1:0] last_angle;
  int                          turn_count;
  longint                      avg_speed_q16;
  longint                      avg_current_q16;
  logic [15:0]                 speed_coef;
  logic [15:0]                 current_coef;

  efu_pkg::efu_out_t feedback_due[$];
  int       mismatches  = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  bit       src_gaps    = 1'b1;
  bit       sink_stalls = 1'b1;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction

  // one first-order low-pass step in q16, floor rounding of the scaled correction
  function automatic longint lowpass_next(input longint y, input logic signed [15:0] x,
                                          input logic [15:0] alpha);
    longint diff;
    diff = (longint'(x) <<< 16) - y;
    return y + ((longint'(alpha) * diff) >>> 16);
  endfunction

  // decode one frame, unwrap the turn count and advance both filters
  function automatic efu_pkg::efu_out_t decode_feedback(input efu_pkg::efu_in_t frame);
    efu_pkg::efu_out_t res;
    int unsigned       frame_angle;
    int                a_now;
    int                a_old;
    int                delta;
    int                degrees;
    longint            sum;
    frame_angle = 32'({frame.angle_high_byte, frame.angle_low_byte});
    a_now       = (frame_angle > TURN - 1) ? TURN - 1 : int'(frame_angle);
    a_old       = int'(last_angle);
    delta       = a_now - a_old;
    // exactly half a turn is kept as it is
    if (delta < -HALF_TURN) delta = delta + TURN;
    else if (delta > HALF_TURN) delta = delta - TURN;
    sum = longint'(turn_count) + delta;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    turn_count = int'(sum);
    last_angle = a_now[efu_pkg::ANGLE_W-1:0];

    res.speed_value   = {frame.speed_high_byte, frame.speed_low_byte};
    res.current_value = {frame.current_high_byte, frame.current_low_byte};
    avg_speed_q16     = lowpass_next(avg_speed_q16, res.speed_value, speed_coef);
    avg_current_q16   = lowpass_next(avg_current_q16, res.current_value, current_coef);

    degrees                  = (a_now * 360 * 256) / TURN;
    res.angle_counts         = a_now[efu_pkg::ANGLE_W-1:0];
    res.angle_degrees_q8     = degrees[efu_pkg::DEG_W-1:0];
    res.temperature          = frame.temperature_byte;
    res.total_angle_counts   = turn_count;
    res.speed_filtered_q16   = avg_speed_q16[31:0];
    res.current_filtered_q16 = avg_current_q16[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  function automatic void check_field(input string name, input logic signed [32:0] want_v,
                                      input logic signed [32:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(input efu_pkg::efu_out_t want,
                                         input efu_pkg::efu_out_t got);
    check_field("angle_counts", 33'(want.angle_counts), 33'(got.angle_counts));
    check_field("angle_degrees_q8", 33'(want.angle_degrees_q8), 33'(got.angle_degrees_q8));
    check_field("speed_value", 33'(want.speed_value), 33'(got.speed_value));
    check_field("current_value", 33'(want.current_value), 33'(got.current_value));
    check_field("temperature", 33'(want.temperature), 33'(got.temperature));
    check_field("total_angle_counts", 33'(want.total_angle_counts),
                33'(got.total_angle_counts));
    check_field("speed_filtered_q16", 33'(want.speed_filtered_q16),
                33'(got.speed_filtered_q16));
    check_field("current_filtered_q16", 33'(want.current_filtered_q16),
                33'(got.current_filtered_q16));
  endfunction

  // predict on every accepted request, then check every accepted result
  always @(posedge clk_i) begin : feedback_monitor
    efu_pkg::efu_out_t want;
    if (rst_ni) begin
      if (frame_if.valid && frame_if.ready)
        feedback_due.push_back(decode_feedback(frame_if.payload));
      if (result_if.valid && result_if.ready) begin
        if (feedback_due.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = feedback_due.pop_front();
          compare_result(want, result_if.payload);
        end
      end
    end
  end

  // watchdog on stretches with no handshake on either side
  always @(posedge clk_i) begin
    if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("encoder_feedback_unwrap_filter_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
      stall_left = idle_length() - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  function automatic efu_pkg::efu_in_t make_frame(input logic [15:0] angle,
                                                  input logic [15:0] speed,
                                                  input logic [15:0] current,
                                                  input logic [7:0] temp);
    efu_pkg::efu_in_t frame;
    {frame.angle_high_byte, frame.angle_low_byte}     = angle;
    {frame.speed_high_byte, frame.speed_low_byte}     = speed;
    {frame.current_high_byte, frame.current_low_byte} = current;
    frame.temperature_byte                            = temp;
    return frame;
  endfunction

  // signed 16-bit word with a bias towards the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd65535;
      2: return 16'd1;
      3: return efu_pkg::ALPHA_RESET;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // hand one request over, holding valid until it is taken
  task automatic send_frame(input efu_pkg::efu_in_t frame);
    int gap;
    gap = (src_gaps && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    if (gap != 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_if.valid   <= 1'b1;
    frame_if.payload <= frame;
    do @(posedge clk_i); while (frame_if.ready !== 1'b1);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_all_results();
    frame_if.valid <= 1'b0;
    @(posedge clk_i);
    while (feedback_due.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  // write both coefficients, only while the block is idle
  task automatic set_alphas(input logic [15:0] a_speed, input logic [15:0] a_current);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= efu_pkg::CFG_SPEED_ALPHA;
    cfg_data_i  <= a_speed;
    @(posedge clk_i);
    cfg_index_i <= efu_pkg::CFG_CURRENT_ALPHA;
    cfg_data_i  <= a_current;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    speed_coef   = a_speed;
    current_coef = a_current;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // field extremes, half-turn boundaries and angle clamping at reset coefficients
  task automatic test_frame_extremes();
    send_frame(make_frame(16'd0, 16'h0000, 16'h0000, 8'h00));
    // exactly half a turn forward and back
    send_frame(make_frame(16'd4096, 16'h7fff, 16'h8000, 8'hff));
    send_frame(make_frame(16'd0, 16'h8000, 16'h7fff, 8'h01));
    // just over half a turn either way
    send_frame(make_frame(16'd4097, 16'hffff, 16'h0001, 8'h80));
    send_frame(make_frame(16'd0, 16'h0001, 16'hffff, 8'h7f));
    // wrap across zero both ways
    send_frame(make_frame(16'd8191, 16'h7fff, 16'h7fff, 8'hff));
    send_frame(make_frame(16'd0, 16'h7fff, 16'h7fff, 8'h00));
    send_frame(make_frame(16'd8191, 16'h8000, 16'h8000, 8'h55));
    // raw angles beyond the encoder range
    send_frame(make_frame(16'd8192, 16'h8000, 16'h8000, 8'haa));
    send_frame(make_frame(16'hffff, 16'h0000, 16'h0000, 8'h00));
    send_frame(make_frame(16'd1, 16'hffff, 16'hffff, 8'hff));
    send_frame(make_frame(16'hff00, 16'h00ff, 16'hff00, 8'h0f));
    send_frame(make_frame(16'd4097, 16'h5555, 16'haaaa, 8'hf0));
    send_frame(make_frame(16'd8191, 16'haaaa, 16'h5555, 8'h33));
    send_frame(make_frame(16'd4095, 16'h0000, 16'h0000, 8'hcc));
    send_frame(make_frame(16'd2048, 16'h7fff, 16'h8000, 8'h00));
    wait_all_results();
  endtask

  // filter coefficient extremes, each followed by a few frames
  task automatic test_filter_coefficients();
    logic [15:0] settings [6][2];
    settings = '{'{16'd0, 16'd0}, '{16'd65535, 16'd65535}, '{16'd0, 16'd65535},
                 '{16'd65535, 16'd0}, '{16'd1, 16'd32768}, '{16'd32768, 16'd1}};
    foreach (settings[s]) begin
      set_alphas(settings[s][0], settings[s][1]);
      repeat (6)
        send_frame(make_frame(16'($urandom_range(0, 8191)), pick_word(), pick_word(),
                              8'($urandom_range(0, 255))));
      wait_all_results();
    end
  endtask

  // mostly continuous angle walks, some half-turn jumps and out-of-range angles
  task automatic test_random_feedback(input int count);
    int          walk_angle;
    int          kind;
    logic [15:0] raw;
    walk_angle = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        wait_all_results();
        if ($urandom_range(0, 1)) set_alphas(pick_alpha(), pick_alpha());
        src_gaps    = ($urandom_range(0, 3) != 0);
        sink_stalls = ($urandom_range(0, 3) != 0);
      end else if (i % 400 == 200) begin
        wait_all_results();
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        walk_angle = (walk_angle + TURN + $urandom_range(0, 600) - 300) % TURN;
        raw = 16'(walk_angle);
      end else if (kind < 85) begin
        walk_angle = (walk_angle + HALF_TURN - 6 + $urandom_range(0, 12)) % TURN;
        raw = 16'(walk_angle);
      end else begin
        raw = (kind < 95) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(8192, 65535));
        walk_angle = (raw > TURN - 1) ? TURN - 1 : int'(raw);
      end
      send_frame(make_frame(raw, pick_word(), pick_word(), 8'($urandom_range(0, 255))));
    end
    wait_all_results();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // full-rate run forward by just under half a turn per request, with a short run back
  task automatic test_full_rate_turns();
    int angle_now;
    wait_all_results();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    angle_now   = int'(last_angle);
    for (int n = 0; n < RUN_LENGTH; n++) begin
      if (n >= RUN_LENGTH - 12 && n < RUN_LENGTH - 7)
        angle_now = (angle_now + HALF_TURN + 1) % TURN;
      else
        angle_now = (angle_now + HALF_TURN - 1) % TURN;
      send_frame(make_frame(16'(angle_now), pick_word(), pick_word(),
                            8'($urandom_range(0, 255))));
    end
    wait_all_results();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence

  initial begin
    rst_ni           = 1'b0;
    frame_if.valid   = 1'b0;
    frame_if.payload = '0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = efu_pkg::CFG_SPEED_ALPHA;
    cfg_data_i       = '0;
    last_angle       = '0;
    turn_count       = 0;
    avg_speed_q16    = 0;
    avg_current_q16  = 0;
    speed_coef       = efu_pkg::ALPHA_RESET;
    current_coef     = efu_pkg::ALPHA_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_extremes();
    test_filter_coefficients();
    test_random_feedback(1800);
    test_full_rate_turns();

    wait_all_results();
    if (mismatches == 0) begin
      $display("encoder_feedback_unwrap_filter_unit: match");
    end else begin
      $display("encoder_feedback_unwrap_filter_unit: mismatch");
    end
    $finish;
  end

endmodule
